// ===== rtl/selective_repeat_sender_window_top_defines.svh =====
// Assertion macros used by the selective repeat sender window design.
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_TOP_DEFINES_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SRSW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SRSW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/srsw_pkg.sv =====
// Package with the types, codes and defaults of the selective repeat sender window.
`default_nettype none

package srsw_pkg;

   localparam int SEQ_COUNT_DEF    = 8;
   localparam int WINDOW_SIZE_DEF  = 4;
   localparam int PAYLOAD_BITS_DEF = 64;

   localparam int NUM_W  = 3;
   localparam int DATA_W = 64;

   typedef enum logic [1:0] {
      OP_SEND    = 2'd0,
      OP_ACK     = 2'd1,
      OP_TIMEOUT = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      TMR_NONE    = 2'd0,
      TMR_START   = 2'd1,
      TMR_STOP    = 2'd2,
      TMR_RESTART = 2'd3
   } timer_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_EXEC  = 2'd1,
      ST_SLIDE = 2'd2
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic walk;
      logic more;
   } sts_type;

endpackage

`default_nettype wire

// ===== rtl/srsw_if.sv =====
// Request and response channel interfaces of the selective repeat sender window.
`default_nettype none

interface srsw_req_if;
   import srsw_pkg::*;

   logic              valid;
   logic              ready;
   logic [1:0]        operation;
   logic [DATA_W-1:0] payload;
   logic [NUM_W-1:0]  ack_number;
   logic              ack_intact;
   logic [NUM_W-1:0]  timeout_number;

   modport source (
      output valid, operation, payload, ack_number, ack_intact, timeout_number,
      input  ready
   );
   modport sink (
      input  valid, operation, payload, ack_number, ack_intact, timeout_number,
      output ready
   );
endinterface

interface srsw_rsp_if;
   import srsw_pkg::*;

   logic              valid;
   logic              ready;
   logic              accepted;
   logic              transmit;
   logic [NUM_W-1:0]  tx_seqnum;
   logic [DATA_W-1:0] tx_payload;
   logic [1:0]        timer_action;
   logic [NUM_W-1:0]  timer_seqnum;
   logic [NUM_W-1:0]  window_base;
   logic [NUM_W-1:0]  next_sequence;
   logic              window_full;

   modport source (
      output valid, accepted, transmit, tx_seqnum, tx_payload, timer_action,
             timer_seqnum, window_base, next_sequence, window_full,
      input  ready
   );
   modport sink (
      input  valid, accepted, transmit, tx_seqnum, tx_payload, timer_action,
             timer_seqnum, window_base, next_sequence, window_full,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/srsw_ctrl.sv =====
// Controller state machine that sequences accept, execute and base slide.
`default_nettype none

`include "selective_repeat_sender_window_top_defines.svh"

module srsw_ctrl
   import srsw_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output cmd_type      cmd,
   input  wire sts_type sts
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ready;
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (sts.walk) begin
               state_in = ST_SLIDE;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_SLIDE: begin
            if (sts.more) begin
               cmd.step = 1'b1;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   `SRSW_ASSERT_NEXT(a_load_to_exec, clock, reset, cmd.load, state_ff == ST_EXEC, "accepted item did not execute")
   `SRSW_ASSERT_NEXT(a_exec_done, clock, reset, (state_ff == ST_EXEC) && !sts.walk, rsp_valid_ff && (state_ff == ST_IDLE), "result missing after execute")
   `SRSW_ASSERT_NEXT(a_slide_holds, clock, reset, (state_ff == ST_SLIDE) && sts.more, (state_ff == ST_SLIDE) && !rsp_valid_ff, "base walk ended early")

endmodule

`default_nettype wire

// ===== rtl/srsw_datapath.sv =====
// Datapath with window pointers, acknowledgement marks, payload store and result register.
`default_nettype none

module srsw_datapath
   import srsw_pkg::*;
#(
   parameter int SEQ_COUNT    = SEQ_COUNT_DEF,
   parameter int WINDOW_SIZE  = WINDOW_SIZE_DEF,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cmd_type           cmd,
   output sts_type                sts,
   input  wire logic [1:0]        operation,
   input  wire logic [DATA_W-1:0] payload,
   input  wire logic [NUM_W-1:0]  ack_number,
   input  wire logic              ack_intact,
   input  wire logic [NUM_W-1:0]  timeout_number,
   output logic                   accepted,
   output logic                   transmit,
   output logic [NUM_W-1:0]       tx_seqnum,
   output logic [DATA_W-1:0]      tx_payload,
   output logic [1:0]             timer_action,
   output logic [NUM_W-1:0]       timer_seqnum,
   output logic [NUM_W-1:0]       window_base,
   output logic [NUM_W-1:0]       next_sequence,
   output logic                   window_full
);

   localparam int SEQ_W = (SEQ_COUNT > 2) ? $clog2(SEQ_COUNT) : 1;
   localparam int CNT_W = SEQ_W + 1;
   localparam int CMP_W = (SEQ_W > NUM_W) ? SEQ_W + 1 : NUM_W + 1;
   localparam int LIMIT = (WINDOW_SIZE < SEQ_COUNT - 1) ? WINDOW_SIZE : SEQ_COUNT - 1;
   localparam logic [SEQ_W-1:0] LAST_SEQ = SEQ_W'(SEQ_COUNT - 1);
   localparam logic [CNT_W-1:0] SEQ_MOD  = CNT_W'(SEQ_COUNT);
   localparam logic [CNT_W-1:0] WIN_LIM  = CNT_W'(LIMIT);
   localparam logic [CMP_W-1:0] SEQ_CMP  = CMP_W'(SEQ_COUNT);

   // Distance from b forward to a on the sequence circle.
   function automatic logic [CNT_W-1:0] seq_offset(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
      logic [CNT_W-1:0] d;
      d = {1'b0, a} - {1'b0, b};
      if (a < b) begin
         d = d + SEQ_MOD;
      end
      return d;
   endfunction

   function automatic logic [SEQ_W-1:0] seq_inc(logic [SEQ_W-1:0] a);
      return (a == LAST_SEQ) ? '0 : a + 1'b1;
   endfunction

   logic [SEQ_W-1:0]        base_ff, base_in;
   logic [SEQ_W-1:0]        next_ff, next_in;
   logic [SEQ_COUNT-1:0]    marks_ff, marks_in;

   op_type                  op_ff;
   logic [PAYLOAD_BITS-1:0] pay_ff;
   logic [NUM_W-1:0]        ack_num_ff;
   logic                    ack_intact_ff;
   logic [NUM_W-1:0]        ton_num_ff;
   logic [PAYLOAD_BITS-1:0] rd_ff;
   logic [PAYLOAD_BITS-1:0] store [SEQ_COUNT];
   logic                    store_we;

   logic                    acc_ff, acc_in;
   logic                    tx_ff, tx_in;
   logic [NUM_W-1:0]        txs_ff, txs_in;
   logic [DATA_W-1:0]       txp_ff, txp_in;
   timer_type               tact_ff, tact_in;
   logic [NUM_W-1:0]        tseq_ff, tseq_in;

   logic [CNT_W-1:0]        count;
   logic                    full;
   logic [SEQ_W-1:0]        ack_idx;
   logic [SEQ_W-1:0]        ton_idx;
   logic                    ack_out;
   logic                    ton_out;

   assign count   = seq_offset(next_ff, base_ff);
   assign full    = count >= WIN_LIM;
   assign ack_idx = SEQ_W'(ack_num_ff);
   assign ton_idx = SEQ_W'(ton_num_ff);
   assign ack_out = (CMP_W'(ack_num_ff) < SEQ_CMP) && (seq_offset(ack_idx, base_ff) < count);
   assign ton_out = (CMP_W'(ton_num_ff) < SEQ_CMP) && (seq_offset(ton_idx, base_ff) < count);

   assign sts.walk = (op_ff == OP_ACK) && ack_intact_ff && ack_out;
   assign sts.more = (base_ff != next_ff) && marks_ff[base_ff];

   always_comb begin
      base_in  = base_ff;
      next_in  = next_ff;
      marks_in = marks_ff;
      store_we = 1'b0;
      acc_in   = acc_ff;
      tx_in    = tx_ff;
      txs_in   = txs_ff;
      txp_in   = txp_ff;
      tact_in  = tact_ff;
      tseq_in  = tseq_ff;
      if (cmd.exec) begin
         acc_in  = 1'b0;
         tx_in   = 1'b0;
         txs_in  = '0;
         txp_in  = '0;
         tact_in = TMR_NONE;
         tseq_in = '0;
         unique case (op_ff)
            OP_SEND: begin
               if (!full) begin
                  store_we          = 1'b1;
                  marks_in[next_ff] = 1'b0;
                  acc_in            = 1'b1;
                  tx_in             = 1'b1;
                  txs_in            = NUM_W'(next_ff);
                  txp_in            = DATA_W'(pay_ff);
                  tact_in           = TMR_START;
                  tseq_in           = NUM_W'(next_ff);
                  next_in           = seq_inc(next_ff);
               end
            end
            OP_ACK: begin
               if (ack_intact_ff) begin
                  tact_in = TMR_STOP;
                  tseq_in = ack_num_ff;
                  if (ack_out) begin
                     acc_in            = 1'b1;
                     marks_in[ack_idx] = 1'b1;
                  end
               end
            end
            OP_TIMEOUT: begin
               if (ton_out && !marks_ff[ton_idx]) begin
                  tx_in   = 1'b1;
                  txs_in  = ton_num_ff;
                  txp_in  = DATA_W'(rd_ff);
                  tact_in = TMR_RESTART;
                  tseq_in = ton_num_ff;
               end
            end
            default: begin
            end
         endcase
      end
      if (cmd.step) begin
         marks_in[base_ff] = 1'b0;
         base_in           = seq_inc(base_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         next_ff  <= '0;
         marks_ff <= '0;
      end else begin
         base_ff  <= base_in;
         next_ff  <= next_in;
         marks_ff <= marks_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff         <= op_type'(operation);
         pay_ff        <= payload[PAYLOAD_BITS-1:0];
         ack_num_ff    <= ack_number;
         ack_intact_ff <= ack_intact;
         ton_num_ff    <= timeout_number;
      end
      acc_ff  <= acc_in;
      tx_ff   <= tx_in;
      txs_ff  <= txs_in;
      txp_ff  <= txp_in;
      tact_ff <= tact_in;
      tseq_ff <= tseq_in;
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store[next_ff] <= pay_ff;
      end
      if (cmd.load) begin
         rd_ff <= store[SEQ_W'(timeout_number)];
      end
   end

   assign accepted      = acc_ff;
   assign transmit      = tx_ff;
   assign tx_seqnum     = txs_ff;
   assign tx_payload    = txp_ff;
   assign timer_action  = tact_ff;
   assign timer_seqnum  = tseq_ff;
   assign window_base   = NUM_W'(base_ff);
   assign next_sequence = NUM_W'(next_ff);
   assign window_full   = full;

endmodule

`default_nettype wire

// ===== rtl/selective_repeat_sender_window_top.sv =====
// Selective repeat ARQ sender window: top level joining controller and datapath.
//
// Usage: each request item is a send, an acknowledgement or a timer expiry, taken on
// req_ch when valid and ready are both high. Each request gives exactly one response
// item on rsp_ch, carrying the transmit, timer action and the window status after it.
// Steps: a send, a timeout or any other acknowledgement passes through the execute state,
// then the output register; an intact acknowledgement inside the window executes, then the
// base walk moves the base over each acknowledged entry at the base, one entry a cycle,
// before the response is registered. A new request is taken only in the idle state.
// The response stays in its output register until taken; a new request is taken in the
// same cycle as the response is taken. While the receiver stalls, req_ch.ready stays low.
// Reset empties the window: base and next sequence return to zero and all marks clear.
// Stored payloads are only read back for outstanding entries, so the store has no clear.
`default_nettype none

module selective_repeat_sender_window_top
   import srsw_pkg::*;
#(
   parameter int SEQ_COUNT    = SEQ_COUNT_DEF,
   parameter int WINDOW_SIZE  = WINDOW_SIZE_DEF,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   srsw_req_if.sink   req_ch,
   srsw_rsp_if.source rsp_ch
);

   cmd_type cmd;
   sts_type sts;

   srsw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   srsw_datapath #(
      .SEQ_COUNT    (SEQ_COUNT),
      .WINDOW_SIZE  (WINDOW_SIZE),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .operation      (req_ch.operation),
      .payload        (req_ch.payload),
      .ack_number     (req_ch.ack_number),
      .ack_intact     (req_ch.ack_intact),
      .timeout_number (req_ch.timeout_number),
      .accepted       (rsp_ch.accepted),
      .transmit       (rsp_ch.transmit),
      .tx_seqnum      (rsp_ch.tx_seqnum),
      .tx_payload     (rsp_ch.tx_payload),
      .timer_action   (rsp_ch.timer_action),
      .timer_seqnum   (rsp_ch.timer_seqnum),
      .window_base    (rsp_ch.window_base),
      .next_sequence  (rsp_ch.next_sequence),
      .window_full    (rsp_ch.window_full)
   );

endmodule

`default_nettype wire
